[hw/rtl/wpd_pkg.sv]
// Shared types and constants of the worker pool dispatcher.
package wpd_pkg;

    localparam int DEF_SLOT_COUNT        = 8;
    localparam int DEF_QUEUE_LENGTH_BITS = 16;

    localparam logic [3:0]  RST_MIN_WORKERS = 4'd1;
    localparam logic [3:0]  RST_MAX_WORKERS = 4'd8;
    localparam logic [14:0] RST_PEND_LIMIT  = 15'd1;
    localparam logic [31:0] RST_IDLE_TMO    = 32'd1000;
    localparam logic [31:0] RST_CHK_PERIOD  = 32'd100;

    typedef enum logic [2:0] {
        ACT_START_POOL = 3'd0,
        ACT_ASSIGN     = 3'd1,
        ACT_REQ_START  = 3'd2,
        ACT_REQ_DONE   = 3'd3,
        ACT_TICK       = 3'd4,
        ACT_LOST       = 3'd5,
        ACT_QREPORT    = 3'd6,
        ACT_NONE       = 3'd7
    } t_action;

    typedef enum logic [2:0] {
        REG_MIN_WORKERS = 3'd0,
        REG_MAX_WORKERS = 3'd1,
        REG_PEND_LIMIT  = 3'd2,
        REG_IDLE_TMO    = 3'd3,
        REG_CHK_PERIOD  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        t_action     action;
        logic [3:0]  slot;
        logic [15:0] queue_length;
    } t_in_word;

    typedef struct packed {
        logic               chosen_valid;
        logic [2:0]         chosen_slot;
        logic               spawned;
        logic               terminated;
        logic [2:0]         changed_slot;
        logic [7:0]         deployed_mask;
        logic [7:0]         busy_mask;
        logic signed [15:0] pend_count;
        logic [3:0]         worker_count;
    } t_out_word;

    typedef struct packed {
        logic [3:0]  min_wkr;
        logic [3:0]  max_wkr;
        logic [14:0] pend_limit;
        logic [31:0] idle_tmo;
        logic [31:0] chk_period;
    } t_cfg;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SINGLE,
        OP_START,
        OP_RR,
        OP_SPAWN,
        OP_LOAD,
        OP_TICK_INC,
        OP_TICK_CHK,
        OP_TICK_SCAN
    } t_dp_op;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_RR,
        IDX_TOP,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    typedef struct packed {
        logic    load;
        t_dp_op  op;
        t_idx_op idx_op;
        logic    emit;
    } t_dp_cmd;

    typedef struct packed {
        logic step_last;
        logic start_go;
        logic slot_free;
        logic slot_empty;
        logic under_max;
        logic check_due;
        logic scale_ok;
        logic timed_out;
        logic out_free;
    } t_dp_stat;

endpackage

[hw/rtl/worker_pool_dispatcher.sv]
// Top level: worker pool dispatcher with register port.
// Request, report and lost actions work in a single step; start pool, assign and
// tick (on a due check) scan the slot tables one slot per cycle.
// One word in flight; the next is taken the cycle after its result registers.
// Reset (synchronous, active low) clears all slots and counters, loads defaults.
module worker_pool_dispatcher #(
    parameter int SLOT_COUNT        = wpd_pkg::DEF_SLOT_COUNT,
    parameter int QUEUE_LENGTH_BITS = wpd_pkg::DEF_QUEUE_LENGTH_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  wpd_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output wpd_pkg::t_out_word o_out_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import wpd_pkg::*;

    t_cfg     r_cfg;
    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_reg_idx reg_sel;
    logic     cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_wkr    <= RST_MIN_WORKERS;
            r_cfg.max_wkr    <= RST_MAX_WORKERS;
            r_cfg.pend_limit <= RST_PEND_LIMIT;
            r_cfg.idle_tmo   <= RST_IDLE_TMO;
            r_cfg.chk_period <= RST_CHK_PERIOD;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_MIN_WORKERS: r_cfg.min_wkr    <= pwdata[3:0];
                REG_MAX_WORKERS: r_cfg.max_wkr    <= pwdata[3:0];
                REG_PEND_LIMIT:  r_cfg.pend_limit <= pwdata[14:0];
                REG_IDLE_TMO:    r_cfg.idle_tmo   <= pwdata;
                REG_CHK_PERIOD:  r_cfg.chk_period <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_MIN_WORKERS: prdata = {28'd0, r_cfg.min_wkr};
            REG_MAX_WORKERS: prdata = {28'd0, r_cfg.max_wkr};
            REG_PEND_LIMIT:  prdata = {17'd0, r_cfg.pend_limit};
            REG_IDLE_TMO:    prdata = r_cfg.idle_tmo;
            REG_CHK_PERIOD:  prdata = r_cfg.chk_period;
            default:         prdata = '0;
        endcase
    end

    wpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_word.action),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    wpd_datapath #(
        .SLOT_COUNT        (SLOT_COUNT),
        .QUEUE_LENGTH_BITS (QUEUE_LENGTH_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

[hw/rtl/wpd_ctrl.sv]
// Sequencer of the worker pool dispatcher: one action at a time, slot scans.
module wpd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  wpd_pkg::t_action  i_action,
    input  wpd_pkg::t_dp_stat i_stat,
    output wpd_pkg::t_dp_cmd  o_cmd,
    output logic              o_in_stall
);
    import wpd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SINGLE,
        S_START,
        S_RR,
        S_SPAWN,
        S_LOAD,
        S_TICK,
        S_TICK_CHK,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.op     = OP_NONE;
        o_cmd.idx_op = IDX_HOLD;
        o_cmd.emit   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_action)
                        ACT_START_POOL: begin
                            o_cmd.idx_op = IDX_ZERO;
                            n_state      = S_START;
                        end
                        ACT_ASSIGN: begin
                            o_cmd.idx_op = IDX_RR;
                            n_state      = S_RR;
                        end
                        ACT_TICK: n_state = S_TICK;
                        ACT_NONE: n_state = S_FINISH;
                        default:  n_state = S_SINGLE;
                    endcase
                end
            end
            S_SINGLE: begin
                o_cmd.op = OP_SINGLE;
                n_state  = S_FINISH;
            end
            S_START: begin
                o_cmd.op = OP_START;
                if (!i_stat.start_go || i_stat.step_last) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                end
            end
            S_RR: begin
                o_cmd.op = OP_RR;
                if (i_stat.slot_free) begin
                    n_state = S_FINISH;
                end else if (i_stat.step_last) begin
                    o_cmd.idx_op = IDX_ZERO;
                    n_state      = i_stat.under_max ? S_SPAWN : S_LOAD;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                end
            end
            S_SPAWN: begin
                o_cmd.op = OP_SPAWN;
                if (i_stat.slot_empty) begin
                    n_state = S_FINISH;
                end else if (i_stat.step_last) begin
                    o_cmd.idx_op = IDX_ZERO;
                    n_state      = S_LOAD;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                end
            end
            S_LOAD: begin
                o_cmd.op = OP_LOAD;
                if (i_stat.step_last) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                end
            end
            S_TICK: begin
                o_cmd.op = OP_TICK_INC;
                n_state  = S_TICK_CHK;
            end
            S_TICK_CHK: begin
                o_cmd.op = OP_TICK_CHK;
                if (i_stat.check_due && i_stat.scale_ok) begin
                    o_cmd.idx_op = IDX_TOP;
                    n_state      = S_SCAN;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SCAN: begin
                o_cmd.op = OP_TICK_SCAN;
                if (i_stat.timed_out || i_stat.step_last) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.idx_op = IDX_DEC;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

[hw/rtl/wpd_datapath.sv]
// Slot state, counters and result word of the worker pool dispatcher.
module wpd_datapath #(
    parameter int SLOT_COUNT        = wpd_pkg::DEF_SLOT_COUNT,
    parameter int QUEUE_LENGTH_BITS = wpd_pkg::DEF_QUEUE_LENGTH_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wpd_pkg::t_in_word  i_in_word,
    input  wpd_pkg::t_cfg      i_cfg,
    input  wpd_pkg::t_dp_cmd   i_cmd,
    input  logic               i_out_stall,
    output wpd_pkg::t_dp_stat  o_stat,
    output logic               o_out_valid,
    output wpd_pkg::t_out_word o_out_word
);
    import wpd_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
    localparam int SW    = (IDX_W > 4) ? IDX_W : 4;
    localparam int QW    = (QUEUE_LENGTH_BITS > 16) ? QUEUE_LENGTH_BITS : 16;
    localparam int MW    = (SLOT_COUNT > 8) ? SLOT_COUNT : 8;
    localparam int CW    = (IDX_W > 3) ? IDX_W : 3;
    localparam logic [IDX_W-1:0] IDX_TOP_V = IDX_W'(SLOT_COUNT - 1);

    t_in_word                     r_item;
    logic [SLOT_COUNT-1:0]        r_dep, n_dep;
    logic [SLOT_COUNT-1:0]        r_busy, n_busy;
    logic [QUEUE_LENGTH_BITS-1:0] r_q [SLOT_COUNT];
    logic [31:0]                  r_last [SLOT_COUNT];
    logic [IDX_W-1:0]             r_rr, n_rr;
    logic signed [15:0]           r_pend, n_pend;
    logic [CNT_W-1:0]             r_total, n_total;
    logic [31:0]                  r_time, n_time;
    logic [31:0]                  r_check, n_check;
    logic [IDX_W-1:0]             r_idx, n_idx;
    logic [IDX_W-1:0]             r_step, n_step;
    logic                         r_found, n_found;
    logic [IDX_W-1:0]             r_chosen, n_chosen;
    logic [QUEUE_LENGTH_BITS-1:0] r_best, n_best;
    logic                         r_spawned, n_spawned;
    logic                         r_term, n_term;
    logic [IDX_W-1:0]             r_changed, n_changed;
    logic                         r_out_valid;
    t_out_word                    r_out_word;

    logic                         la_we;
    logic [IDX_W-1:0]             la_addr;
    logic                         q_we;
    logic [SW:0]                  slot_w;
    logic [IDX_W-1:0]             slot_idx;
    logic                         slot_ok;
    logic                         dep_s;
    logic [SLOT_COUNT-1:0]        free_v;
    logic [IDX_W-1:0]             idx_next;
    logic [31:0]                  diff_i;
    logic [QW-1:0]                q_in_w;
    logic [MW-1:0]                dep_w, busy_w;
    logic [CW-1:0]                chosen_w, changed_w;
    logic [CMP_W-1:0]             total_w;
    t_out_word                    ow;

    assign slot_w   = (SW + 1)'(r_item.slot);
    assign slot_idx = slot_w[IDX_W-1:0];
    assign slot_ok  = slot_w < (SW + 1)'(SLOT_COUNT);
    assign dep_s    = r_dep[slot_idx];
    assign free_v   = r_dep & ~r_busy;
    assign idx_next = (r_idx == IDX_TOP_V) ? '0 : r_idx + 1'b1;
    assign diff_i   = r_time - r_last[r_idx];
    assign q_in_w   = QW'(r_item.queue_length);
    assign total_w  = CMP_W'(r_total);

    always_comb begin
        o_stat.step_last  = (r_step == IDX_TOP_V);
        o_stat.start_go   = CMP_W'(r_idx) < CMP_W'(i_cfg.min_wkr);
        o_stat.slot_free  = free_v[r_idx];
        o_stat.slot_empty = !r_dep[r_idx];
        o_stat.under_max  = total_w < CMP_W'(i_cfg.max_wkr);
        o_stat.check_due  = (r_time - r_check) >= i_cfg.chk_period;
        o_stat.scale_ok   = ($signed({r_pend[15], r_pend}) < $signed({2'b00, i_cfg.pend_limit}))
                            && ((free_v & (free_v - SLOT_COUNT'(1))) != '0);
        o_stat.timed_out  = free_v[r_idx] && (diff_i > i_cfg.idle_tmo);
        o_stat.out_free   = !r_out_valid || !i_out_stall;
    end

    always_comb begin
        n_dep     = r_dep;
        n_busy    = r_busy;
        n_rr      = r_rr;
        n_pend    = r_pend;
        n_total   = r_total;
        n_time    = r_time;
        n_check   = r_check;
        n_found   = r_found;
        n_chosen  = r_chosen;
        n_best    = r_best;
        n_spawned = r_spawned;
        n_term    = r_term;
        n_changed = r_changed;
        la_we     = 1'b0;
        la_addr   = r_idx;
        q_we      = 1'b0;
        case (i_cmd.op)
            OP_SINGLE: begin
                case (r_item.action)
                    ACT_REQ_START: begin
                        if (r_pend != 16'sh7fff) n_pend = r_pend + 16'sd1;
                        if (slot_ok && dep_s) begin
                            n_busy[slot_idx] = 1'b1;
                            la_we            = 1'b1;
                            la_addr          = slot_idx;
                        end
                    end
                    ACT_REQ_DONE: begin
                        if (r_pend != -16'sh8000) n_pend = r_pend - 16'sd1;
                        if (slot_ok && dep_s) begin
                            n_busy[slot_idx] = 1'b0;
                            la_we            = 1'b1;
                            la_addr          = slot_idx;
                        end
                    end
                    ACT_LOST: begin
                        if (slot_ok && dep_s) begin
                            n_term           = 1'b1;
                            n_changed        = slot_idx;
                            n_busy[slot_idx] = 1'b0;
                            if (total_w - CMP_W'(1) < CMP_W'(i_cfg.min_wkr)) begin
                                n_spawned = 1'b1;
                                la_we     = 1'b1;
                                la_addr   = slot_idx;
                            end else begin
                                n_dep[slot_idx] = 1'b0;
                                n_total         = r_total - 1'b1;
                            end
                        end
                    end
                    ACT_QREPORT: q_we = slot_ok;
                    default: ;
                endcase
            end
            OP_START, OP_SPAWN: begin
                if (!r_dep[r_idx] && (i_cmd.op == OP_SPAWN || o_stat.start_go)) begin
                    n_dep[r_idx]  = 1'b1;
                    n_busy[r_idx] = 1'b0;
                    la_we         = 1'b1;
                    n_total       = r_total + 1'b1;
                    n_spawned     = 1'b1;
                    n_changed     = r_idx;
                    if (i_cmd.op == OP_SPAWN) begin
                        n_found  = 1'b1;
                        n_chosen = r_idx;
                    end
                end
            end
            OP_RR: begin
                n_rr = idx_next;
                if (free_v[r_idx]) begin
                    n_found  = 1'b1;
                    n_chosen = r_idx;
                end
            end
            OP_LOAD: begin
                if (r_dep[r_idx] && (!r_found || r_q[r_idx] < r_best)) begin
                    n_found  = 1'b1;
                    n_chosen = r_idx;
                    n_best   = r_q[r_idx];
                end
            end
            OP_TICK_INC: n_time = r_time + 32'd1;
            OP_TICK_CHK: begin
                if (o_stat.check_due) n_check = r_time;
            end
            OP_TICK_SCAN: begin
                if (o_stat.timed_out) begin
                    n_dep[r_idx]  = 1'b0;
                    n_busy[r_idx] = 1'b0;
                    n_total       = r_total - 1'b1;
                    n_term        = 1'b1;
                    n_changed     = r_idx;
                end
            end
            default: ;
        endcase
        if (i_cmd.load) begin
            n_found   = 1'b0;
            n_chosen  = '0;
            n_spawned = 1'b0;
            n_term    = 1'b0;
            n_changed = '0;
        end
    end

    always_comb begin
        n_idx  = r_idx;
        n_step = r_step;
        case (i_cmd.idx_op)
            IDX_ZERO: begin n_idx = '0;        n_step = '0; end
            IDX_RR:   begin n_idx = r_rr;      n_step = '0; end
            IDX_TOP:  begin n_idx = IDX_TOP_V; n_step = '0; end
            IDX_INC:  begin n_idx = idx_next;  n_step = r_step + 1'b1; end
            IDX_DEC:  begin n_idx = r_idx - 1'b1; n_step = r_step + 1'b1; end
            default: ;
        endcase
    end

    assign dep_w     = MW'(r_dep);
    assign busy_w    = MW'(r_busy);
    assign chosen_w  = CW'(r_chosen);
    assign changed_w = CW'(r_changed);

    always_comb begin
        ow.chosen_valid  = r_found;
        ow.chosen_slot   = chosen_w[2:0];
        ow.spawned       = r_spawned;
        ow.terminated    = r_term;
        ow.changed_slot  = changed_w[2:0];
        ow.deployed_mask = dep_w[7:0];
        ow.busy_mask     = busy_w[7:0];
        ow.pend_count    = r_pend;
        ow.worker_count  = total_w[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_last[i] <= '0;
                r_q[i]    <= '0;
            end
        end else begin
            if (la_we) r_last[la_addr] <= r_time;
            if (q_we)  r_q[slot_idx]   <= q_in_w[QUEUE_LENGTH_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dep       <= '0;
            r_busy      <= '0;
            r_rr        <= '0;
            r_pend      <= '0;
            r_total     <= '0;
            r_time      <= '0;
            r_check     <= '0;
            r_idx       <= '0;
            r_step      <= '0;
            r_found     <= 1'b0;
            r_chosen    <= '0;
            r_spawned   <= 1'b0;
            r_term      <= 1'b0;
            r_changed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_dep     <= n_dep;
            r_busy    <= n_busy;
            r_rr      <= n_rr;
            r_pend    <= n_pend;
            r_total   <= n_total;
            r_time    <= n_time;
            r_check   <= n_check;
            r_idx     <= n_idx;
            r_step    <= n_step;
            r_found   <= n_found;
            r_chosen  <= n_chosen;
            r_spawned <= n_spawned;
            r_term    <= n_term;
            r_changed <= n_changed;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_best <= n_best;
        if (i_cmd.load) r_item     <= i_in_word;
        if (i_cmd.emit) r_out_word <= ow;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

[hw/rtl/wpd_checker.sv]
// Port-level checks of the worker pool dispatcher, bound to the top level.
module wpd_port_checker #(
    parameter int SLOT_COUNT = wpd_pkg::DEF_SLOT_COUNT
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input wpd_pkg::t_out_word o_out_word
);
    import wpd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result word changed");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word taken while one is in work");

    a_busy_deployed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.busy_mask & ~o_out_word.deployed_mask) == 8'd0)
        else $error("busy slot not deployed");

    a_changed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.spawned && !o_out_word.terminated
        |-> o_out_word.changed_slot == 3'd0)
        else $error("changed slot set with no change");

    a_count_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (SLOT_COUNT <= 8)
        |-> $countones(o_out_word.deployed_mask) == int'(o_out_word.worker_count))
        else $error("worker count disagrees with deployed mask");

endmodule

bind worker_pool_dispatcher wpd_port_checker #(.SLOT_COUNT(SLOT_COUNT)) u_wpd_checker (.*);

[tb/wpd_checker.sv]
// Checker for the worker pool dispatcher: predicts each result word and compares it.
module wpd_checker
    import wpd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_word i_out_word,
    input  logic      i_psel,
    input  logic      i_penable,
    input  logic      i_pwrite,
    input  logic      i_pready,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int        o_fail_count,
    output int        o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 8;

    logic [3:0]  cfg_min;
    logic [3:0]  cfg_max;
    logic [14:0] cfg_pend_limit;
    logic [31:0] cfg_idle_tmo;
    logic [31:0] cfg_period;

    logic [7:0]  deployed;
    logic [7:0]  busy;
    logic [15:0] qlen [SLOTS];
    logic [31:0] last_act [SLOTS];
    logic [2:0]  rr_ptr;
    int          pending;
    int          workers;
    logic [31:0] now_ticks;
    logic [31:0] last_check;

    t_out_word   expected_q[$];
    int          fails;

    function automatic void add_worker(int s);
        deployed[s] = 1'b1;
        busy[s]     = 1'b0;
        last_act[s] = now_ticks;
        workers++;
    endfunction

    function automatic void drop_worker(int s);
        deployed[s] = 1'b0;
        busy[s]     = 1'b0;
        workers--;
    endfunction

    function automatic void bump_pending(int d);
        pending = pending + d;
        if (pending > 32767) pending = 32767;
        if (pending < -32768) pending = -32768;
    endfunction

    function automatic t_out_word dispatch(t_in_word w);
        t_out_word   r;
        int          i;
        int          s;
        bit          found;
        logic [15:0] best;
        int          idle;
        bit          ok;
        r     = '0;
        ok    = w.slot < SLOTS;
        found = 0;
        best  = '0;
        case (w.action)
            ACT_START_POOL: begin
                for (i = 0; i < SLOTS && i < cfg_min; i++) begin
                    if (!deployed[i]) begin
                        add_worker(i);
                        r.spawned      = 1'b1;
                        r.changed_slot = i[2:0];
                    end
                end
            end
            ACT_ASSIGN: begin
                for (i = 0; i < SLOTS && !found; i++) begin
                    s = rr_ptr;
                    rr_ptr = rr_ptr + 3'd1;
                    if (deployed[s] && !busy[s]) begin
                        found = 1;
                        r.chosen_slot = s[2:0];
                    end
                end
                if (!found && workers < cfg_max) begin
                    for (i = 0; i < SLOTS && !found; i++) begin
                        if (!deployed[i]) begin
                            add_worker(i);
                            r.spawned      = 1'b1;
                            r.changed_slot = i[2:0];
                            r.chosen_slot  = i[2:0];
                            found = 1;
                        end
                    end
                end
                if (!found) begin
                    for (i = 0; i < SLOTS; i++) begin
                        if (deployed[i] && (!found || qlen[i] < best)) begin
                            best = qlen[i];
                            r.chosen_slot = i[2:0];
                            found = 1;
                        end
                    end
                end
                r.chosen_valid = found;
                if (!found) r.chosen_slot = '0;
            end
            ACT_REQ_START: begin
                bump_pending(1);
                if (ok && deployed[w.slot]) begin
                    busy[w.slot]     = 1'b1;
                    last_act[w.slot] = now_ticks;
                end
            end
            ACT_REQ_DONE: begin
                bump_pending(-1);
                if (ok && deployed[w.slot]) begin
                    busy[w.slot]     = 1'b0;
                    last_act[w.slot] = now_ticks;
                end
            end
            ACT_TICK: begin
                now_ticks = now_ticks + 32'd1;
                if (32'(now_ticks - last_check) >= cfg_period) begin
                    last_check = now_ticks;
                    idle = 0;
                    for (i = 0; i < SLOTS; i++)
                        if (deployed[i] && !busy[i]) idle++;
                    if (pending < int'(cfg_pend_limit) && idle > 1) begin
                        for (i = SLOTS - 1; i >= 0; i--) begin
                            if (deployed[i] && !busy[i] &&
                                32'(now_ticks - last_act[i]) > cfg_idle_tmo) begin
                                drop_worker(i);
                                r.terminated   = 1'b1;
                                r.changed_slot = i[2:0];
                                break;
                            end
                        end
                    end
                end
            end
            ACT_LOST: begin
                if (ok && deployed[w.slot]) begin
                    drop_worker(w.slot);
                    r.terminated   = 1'b1;
                    r.changed_slot = w.slot[2:0];
                    if (workers < cfg_min) begin
                        add_worker(w.slot);
                        r.spawned = 1'b1;
                    end
                end
            end
            ACT_QREPORT: begin
                if (ok) qlen[w.slot] = w.queue_length;
            end
            default: ;
        endcase
        r.deployed_mask = deployed;
        r.busy_mask     = busy;
        r.pend_count    = pending[15:0];
        r.worker_count  = workers[3:0];
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_word e;
        int        i;
        if (!i_rst_n) begin
            cfg_min        = RST_MIN_WORKERS;
            cfg_max        = RST_MAX_WORKERS;
            cfg_pend_limit = RST_PEND_LIMIT;
            cfg_idle_tmo   = RST_IDLE_TMO;
            cfg_period     = RST_CHK_PERIOD;
            deployed   = '0;
            busy       = '0;
            for (i = 0; i < SLOTS; i++) begin
                qlen[i]     = '0;
                last_act[i] = '0;
            end
            rr_ptr     = '0;
            pending    = 0;
            workers    = 0;
            now_ticks  = '0;
            last_check = '0;
            expected_q.delete();
            fails      = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_MIN_WORKERS: cfg_min        = i_pwdata[3:0];
                    REG_MAX_WORKERS: cfg_max        = i_pwdata[3:0];
                    REG_PEND_LIMIT:  cfg_pend_limit = i_pwdata[14:0];
                    REG_IDLE_TMO:    cfg_idle_tmo   = i_pwdata;
                    REG_CHK_PERIOD:  cfg_period     = i_pwdata;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                expected_q.push_back(dispatch(i_in_word));
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result word with no expected word waiting");
                    fails++;
                end else begin
                    e = expected_q.pop_front();
                    check_field("chosen_valid", e.chosen_valid, i_out_word.chosen_valid);
                    check_field("chosen_slot", e.chosen_slot, i_out_word.chosen_slot);
                    check_field("spawned", e.spawned, i_out_word.spawned);
                    check_field("terminated", e.terminated, i_out_word.terminated);
                    check_field("changed_slot", e.changed_slot, i_out_word.changed_slot);
                    check_field("deployed_mask", e.deployed_mask, i_out_word.deployed_mask);
                    check_field("busy_mask", e.busy_mask, i_out_word.busy_mask);
                    check_field("pend_count", 32'(e.pend_count),
                                32'(i_out_word.pend_count));
                    check_field("worker_count", e.worker_count, i_out_word.worker_count);
                end
            end
        end
        o_fail_count  <= fails;
        o_outstanding <= expected_q.size();
    end

endmodule

[tb/tb_top.sv]
// Testbench top: stimulus, register setup, watchdog and verdict for the dispatcher.
module tb_top;
    import wpd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_word    in_word;
    logic        out_valid;
    logic        out_stall;
    t_out_word   out_word;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          outstanding;
    bit          idle_on;
    int          quiet_cycles;

    worker_pool_dispatcher dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    wpd_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_word     (in_word),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_word    (out_word),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        out_stall <= idle_on && ($urandom_range(99) < 36);
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input t_in_word w);
        if (idle_on && $urandom_range(99) < 36) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < 36) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic send(input t_action a, input logic [3:0] s, input logic [15:0] q);
        t_in_word w;
        w.action       = a;
        w.slot         = s;
        w.queue_length = q;
        send_word(w);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_pool(input logic [3:0] mn, input logic [3:0] mx, input logic [14:0] lim,
                            input logic [31:0] tmo, input logic [31:0] per);
        write_reg(REG_MIN_WORKERS, mn);
        write_reg(REG_MAX_WORKERS, mx);
        write_reg(REG_PEND_LIMIT, lim);
        write_reg(REG_IDLE_TMO, tmo);
        write_reg(REG_CHK_PERIOD, per);
    endtask

    function automatic t_in_word random_word();
        t_in_word w;
        int       r;
        r = $urandom_range(99);
        w.slot = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 8)) : 4'($urandom_range(7));
        case ($urandom_range(9))
            0:       w.queue_length = 16'h0000;
            1:       w.queue_length = 16'hFFFF;
            default: w.queue_length = 16'($urandom);
        endcase
        if (r < 4) begin
            w.action = t_action'($urandom_range(7));
            w.slot   = 4'($urandom_range(15));
        end else if (r < 7)  w.action = ACT_START_POOL;
        else if (r < 32)     w.action = ACT_ASSIGN;
        else if (r < 52)     w.action = ACT_REQ_START;
        else if (r < 72)     w.action = ACT_REQ_DONE;
        else if (r < 88)     w.action = ACT_TICK;
        else if (r < 93)     w.action = ACT_LOST;
        else                 w.action = ACT_QREPORT;
        return w;
    endfunction

    task automatic random_burst(input int n, input bit pause_mid);
        int k;
        for (k = 0; k < n; k++) begin
            if (pause_mid && k == n / 2) drain();
            send_word(random_word());
        end
    endtask

    initial begin
        i_rst_n  = 1'b0;
        in_valid = 1'b0;
        in_word  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        idle_on  = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: defaults first, then a short timeout
        send(ACT_ASSIGN, 4'd0, 16'd0);
        send(ACT_NONE, 4'd15, 16'hFFFF);
        send(ACT_START_POOL, 4'd0, 16'd0);
        drain();
        set_pool(4'd3, 4'd8, 15'd1, 32'd2, 32'd0);
        send(ACT_START_POOL, 4'd0, 16'd0);
        send(ACT_QREPORT, 4'd0, 16'hFFFF);
        send(ACT_QREPORT, 4'd1, 16'h0000);
        send(ACT_QREPORT, 4'd15, 16'h1234);
        send(ACT_QREPORT, 4'd7, 16'h0042);
        send(ACT_REQ_START, 4'd0, 16'd0);
        send(ACT_REQ_START, 4'd1, 16'd0);
        send(ACT_REQ_START, 4'd2, 16'd0);
        send(ACT_ASSIGN, 4'd0, 16'd0);
        send(ACT_ASSIGN, 4'd0, 16'd0);
        send(ACT_REQ_START, 4'd9, 16'd0);
        send(ACT_REQ_DONE, 4'd12, 16'd0);
        send(ACT_REQ_DONE, 4'd1, 16'd0);
        send(ACT_REQ_DONE, 4'd6, 16'd0);
        send(ACT_LOST, 4'd1, 16'd0);
        send(ACT_LOST, 4'd5, 16'd0);
        send(ACT_LOST, 4'd14, 16'd0);
        send(ACT_TICK, 4'd0, 16'd0);
        send(ACT_TICK, 4'd0, 16'd0);
        send(ACT_TICK, 4'd0, 16'd0);
        send(ACT_TICK, 4'd0, 16'd0);
        drain();

        set_pool(4'd0, 4'd0, 15'd0, 32'd0, 32'd1);
        send(ACT_ASSIGN, 4'd0, 16'd0);
        random_burst(150, 1'b0);
        drain();

        idle_on = 1'b0;
        set_pool(4'd8, 4'd8, 15'd32767, 32'd0, 32'd0);
        random_burst(170, 1'b0);
        drain();
        idle_on = 1'b1;

        set_pool(4'd3, 4'd5, 15'd5, 32'd5, 32'd1);
        random_burst(170, 1'b1);
        drain();

        set_pool(4'd8, 4'd8, 15'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_burst(160, 1'b0);
        drain();

        set_pool(4'd2, 4'd4, 15'd1, 32'd10, 32'd2);
        random_burst(170, 1'b0);
        drain();

        repeat (30) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/wpd_pkg.sv
hw/rtl/wpd_ctrl.sv
hw/rtl/wpd_datapath.sv
hw/rtl/worker_pool_dispatcher.sv
hw/rtl/wpd_checker.sv
tb/wpd_checker.sv
tb/tb_top.sv
